// ===== hdl/phdm_pkg.sv =====
// Shared types, constants and the control store for the peak-hold meter.
package phdm_pkg;

  localparam int LEVEL_W = 16;
  localparam int RATIO_W = LEVEL_W + 1;
  localparam int PROD_W  = 2 * LEVEL_W;
  localparam int ACC_W   = 3 * LEVEL_W;
  localparam int CNT_W   = $clog2(LEVEL_W + 2);
  localparam int STEP_W  = 4;

  localparam logic [CNT_W-1:0] CNT_RATIO = CNT_W'(LEVEL_W + 1);
  localparam logic [CNT_W-1:0] CNT_DECAY = CNT_W'(LEVEL_W);

  localparam logic [LEVEL_W-1:0] HOLD_RST = LEVEL_W'(21);
  localparam logic [LEVEL_W-1:0] COLL_RST = LEVEL_W'(69);

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;

  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_COLL = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_DECAY = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    UOP_ACCEPT,   // take an item and update the trail state
    UOP_SQ_D,     // prod = collapse^2
    UOP_SQ_R,     // divisor = prod, prod = rem^2
    UOP_LO,       // keep rem^2 high half, prod = diff * rem^2 low half
    UOP_HI,       // acc = prod, prod = diff * rem^2 high half
    UOP_SUM,      // acc += prod << LEVEL_W
    UOP_DINIT,    // load divider with acc / divisor
    UOP_DSTEP,    // one restoring division bit
    UOP_GHOST,    // ghost = current + quotient
    UOP_RINIT_C,  // load divider with current ratio
    UOP_RINIT_G,  // save current ratio, load divider with ghost ratio
    UOP_FINISH    // move results to the output register
  } uop_t;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_WAIT_IN,  // hold until an input beat arrives
    CND_SKIP,     // jump to target when no decay evaluation is due
    CND_LOOP,     // repeat until the division count runs out
    CND_OUT       // hold while the output register is full, then jump
  } cond_t;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] ST_ACCEPT  = 4'd0;
  localparam logic [STEP_W-1:0] ST_SQ_D    = 4'd1;
  localparam logic [STEP_W-1:0] ST_SQ_R    = 4'd2;
  localparam logic [STEP_W-1:0] ST_LO      = 4'd3;
  localparam logic [STEP_W-1:0] ST_HI      = 4'd4;
  localparam logic [STEP_W-1:0] ST_SUM     = 4'd5;
  localparam logic [STEP_W-1:0] ST_DINIT   = 4'd6;
  localparam logic [STEP_W-1:0] ST_DDIV    = 4'd7;
  localparam logic [STEP_W-1:0] ST_GHOST   = 4'd8;
  localparam logic [STEP_W-1:0] ST_RINIT_C = 4'd9;
  localparam logic [STEP_W-1:0] ST_CDIV    = 4'd10;
  localparam logic [STEP_W-1:0] ST_RINIT_G = 4'd11;
  localparam logic [STEP_W-1:0] ST_GDIV    = 4'd12;
  localparam logic [STEP_W-1:0] ST_FINISH  = 4'd13;

  function automatic ucode_t ucode(input logic [STEP_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      ST_ACCEPT:  w = '{UOP_ACCEPT,  CND_WAIT_IN, ST_ACCEPT};
      ST_SQ_D:    w = '{UOP_SQ_D,    CND_SKIP,    ST_RINIT_C};
      ST_SQ_R:    w = '{UOP_SQ_R,    CND_NEXT,    ST_ACCEPT};
      ST_LO:      w = '{UOP_LO,      CND_NEXT,    ST_ACCEPT};
      ST_HI:      w = '{UOP_HI,      CND_NEXT,    ST_ACCEPT};
      ST_SUM:     w = '{UOP_SUM,     CND_NEXT,    ST_ACCEPT};
      ST_DINIT:   w = '{UOP_DINIT,   CND_NEXT,    ST_ACCEPT};
      ST_DDIV:    w = '{UOP_DSTEP,   CND_LOOP,    ST_ACCEPT};
      ST_GHOST:   w = '{UOP_GHOST,   CND_NEXT,    ST_ACCEPT};
      ST_RINIT_C: w = '{UOP_RINIT_C, CND_NEXT,    ST_ACCEPT};
      ST_CDIV:    w = '{UOP_DSTEP,   CND_LOOP,    ST_ACCEPT};
      ST_RINIT_G: w = '{UOP_RINIT_G, CND_NEXT,    ST_ACCEPT};
      ST_GDIV:    w = '{UOP_DSTEP,   CND_LOOP,    ST_ACCEPT};
      ST_FINISH:  w = '{UOP_FINISH,  CND_OUT,     ST_ACCEPT};
      default:    w = '{UOP_FINISH,  CND_OUT,     ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/peak_hold_eased_decay_meter.sv =====
// Level meter with a held ghost peak and quadratic ease-out decay, Q1.16 ratio outputs.
// An item is taken only at the accept step of a small microprogram; its result is
// loaded into the output register at the microprogram's last step, and the next item
// is taken the cycle after that. The microprogram runs a one-bit-per-cycle restoring
// divider once for each ratio (17 steps each) and, when a tick evaluates the decay
// curve, once for the decay fraction (16 steps), after four passes through a shared
// 16x16 multiplier. The output register holds a result until out_ready takes it
// while the next item is already being worked on.
module peak_hold_eased_decay_meter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic [phdm_pkg::LEVEL_W-1:0]    in_level,
  input  logic [phdm_pkg::LEVEL_W-1:0]    in_full_scale,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [phdm_pkg::RATIO_W-1:0]    out_current_ratio,
  output logic [phdm_pkg::RATIO_W-1:0]    out_ghost_ratio,
  output logic [phdm_pkg::LEVEL_W-1:0]    out_ghost_level,
  output logic [1:0]                      out_trail_mode,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [phdm_pkg::LEVEL_W-1:0]    cfg_wdata
);
  import phdm_pkg::*;

  localparam int L = LEVEL_W;

  logic [L-1:0]        hold_r, hold_nxt, coll_r, coll_nxt;
  logic [L-1:0]        fs_r, fs_nxt, cur_r, cur_nxt, ghost_r, ghost_nxt;
  logic [L-1:0]        start_r, start_nxt, el_r, el_nxt;
  mode_t               mode_r, mode_nxt;
  logic                base_r, base_nxt, need_div_r, need_div_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic [PROD_W-1:0]   prod_r, prod_nxt, m_r, m_nxt, r_r, r_nxt;
  logic [L-1:0]        sq_hi_r, sq_hi_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [L:0]          s_r, s_nxt, q_r, q_nxt, cr_r, cr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [RATIO_W-1:0]  out_cur_r, out_cur_nxt, out_ghr_r, out_ghr_nxt;
  logic [L-1:0]        out_gl_r, out_gl_nxt;
  mode_t               out_mode_r, out_mode_nxt;

  ucode_t              uw;
  logic                out_busy, snap;
  logic [L-1:0]        fs_in, lvl_in, el_inc, g_max, rem, diff, mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W:0]     div_t, div_sub;
  logic                div_ge;
  logic [L:0]          g_sum;

  assign uw       = ucode(step_r);
  assign in_ready = (uw.op == UOP_ACCEPT);
  assign out_busy = out_valid_r && !out_ready;

  assign fs_in  = (in_full_scale == '0) ? L'(1) : in_full_scale;
  assign lvl_in = (in_level > fs_in) ? fs_in : in_level;
  assign el_inc = (el_r == '1) ? el_r : el_r + L'(1);
  assign g_max  = (ghost_r < cur_r) ? cur_r : ghost_r;
  assign rem    = coll_r - el_r;
  assign diff   = (start_r > cur_r) ? start_r - cur_r : '0;

  // restoring division: one quotient bit per step
  assign div_t   = {r_r, s_r[L]};
  assign div_ge  = div_t >= {1'b0, m_r};
  assign div_sub = div_t - {1'b0, m_r};
  assign g_sum   = {1'b0, cur_r} + q_r;

  always_comb begin
    unique case (uw.op)
      UOP_SQ_D: begin mul_a = coll_r; mul_b = coll_r;          end
      UOP_SQ_R: begin mul_a = rem;    mul_b = rem;             end
      UOP_LO:   begin mul_a = diff;   mul_b = prod_r[L-1:0];   end
      UOP_HI:   begin mul_a = diff;   mul_b = sq_hi_r;         end
      default:  begin mul_a = '0;     mul_b = '0;              end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    hold_nxt      = hold_r;
    coll_nxt      = coll_r;
    fs_nxt        = fs_r;
    cur_nxt       = cur_r;
    ghost_nxt     = ghost_r;
    start_nxt     = start_r;
    el_nxt        = el_r;
    mode_nxt      = mode_r;
    base_nxt      = base_r;
    need_div_nxt  = need_div_r;
    prod_nxt      = prod_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    sq_hi_nxt     = sq_hi_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    q_nxt         = q_r;
    cr_nxt        = cr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_busy;
    out_cur_nxt   = out_cur_r;
    out_ghr_nxt   = out_ghr_r;
    out_gl_nxt    = out_gl_r;
    out_mode_nxt  = out_mode_r;
    snap          = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD: hold_nxt = cfg_wdata;
        REG_COLL: coll_nxt = cfg_wdata;
      endcase
    end

    unique case (uw.cond)
      CND_NEXT:    step_nxt = step_r + STEP_W'(1);
      CND_WAIT_IN: step_nxt = in_valid ? step_r + STEP_W'(1) : step_r;
      CND_SKIP:    step_nxt = need_div_r ? step_r + STEP_W'(1) : uw.target;
      CND_LOOP:    step_nxt = (cnt_r != CNT_W'(1)) ? step_r : step_r + STEP_W'(1);
      CND_OUT:     step_nxt = out_busy ? step_r : uw.target;
      default:     step_nxt = ST_ACCEPT;
    endcase

    unique case (uw.op)
      UOP_ACCEPT: begin
        if (in_valid) begin
          need_div_nxt = 1'b0;
          snap = (in_command == CMD_SNAP) || ((in_command == CMD_UPDATE) && !base_r);
          if (snap) begin
            fs_nxt    = fs_in;
            cur_nxt   = lvl_in;
            ghost_nxt = lvl_in;
            start_nxt = lvl_in;
            el_nxt    = '0;
            mode_nxt  = MODE_IDLE;
            base_nxt  = 1'b1;
          end else if (in_command == CMD_UPDATE) begin
            fs_nxt  = fs_in;
            cur_nxt = lvl_in;
            if ((fs_in != fs_r) || ((lvl_in > cur_r) && (lvl_in >= ghost_r))) begin
              ghost_nxt = lvl_in;
              start_nxt = lvl_in;
              el_nxt    = '0;
              mode_nxt  = MODE_IDLE;
            end else if (lvl_in < cur_r) begin
              // drop: hold at the old peak, go straight to decay, or follow the level if no decay
              start_nxt = g_max;
              ghost_nxt = g_max;
              el_nxt    = '0;
              if (hold_r != '0) begin
                mode_nxt = MODE_HOLD;
              end else if (coll_r == '0) begin
                ghost_nxt = lvl_in;
                mode_nxt  = MODE_IDLE;
              end else begin
                mode_nxt = MODE_DECAY;
              end
            end
          end else if ((in_command == CMD_TICK) && (mode_r != MODE_IDLE)) begin
            el_nxt = el_inc;
            if (mode_r == MODE_HOLD) begin
              if (el_inc >= hold_r) begin
                mode_nxt  = MODE_DECAY;
                el_nxt    = '0;
                start_nxt = ghost_r;
                if (coll_r == '0) begin
                  ghost_nxt = cur_r;
                  mode_nxt  = MODE_IDLE;
                end else begin
                  need_div_nxt = 1'b1;
                end
              end
            end else if ((coll_r == '0) || (el_inc >= coll_r)) begin
              ghost_nxt = cur_r;
              mode_nxt  = MODE_IDLE;
            end else begin
              need_div_nxt = 1'b1;
            end
          end
          if (ghost_nxt < cur_nxt) ghost_nxt = cur_nxt;
          if (ghost_nxt > fs_nxt)  ghost_nxt = fs_nxt;
        end
      end
      UOP_SQ_D: prod_nxt = mul_p;
      UOP_SQ_R: begin
        m_nxt    = prod_r;
        prod_nxt = mul_p;
      end
      UOP_LO: begin
        sq_hi_nxt = prod_r[PROD_W-1:L];
        prod_nxt  = mul_p;
      end
      UOP_HI: begin
        acc_nxt  = {{L{1'b0}}, prod_r};
        prod_nxt = mul_p;
      end
      UOP_SUM: acc_nxt = acc_r + {prod_r, {L{1'b0}}};
      UOP_DINIT: begin
        // quotient is below 2^L, so the upper bits already sit under the divisor
        r_nxt   = acc_r[ACC_W-1:L];
        s_nxt   = {acc_r[L-1:0], 1'b0};
        q_nxt   = '0;
        cnt_nxt = CNT_DECAY;
      end
      UOP_DSTEP: begin
        r_nxt   = div_ge ? div_sub[PROD_W-1:0] : div_t[PROD_W-1:0];
        q_nxt   = {q_r[L-1:0], div_ge};
        s_nxt   = {s_r[L-1:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      UOP_GHOST: ghost_nxt = (g_sum > {1'b0, fs_r}) ? fs_r : g_sum[L-1:0];
      UOP_RINIT_C: begin
        m_nxt   = {{L{1'b0}}, fs_r};
        r_nxt   = {{(L+1){1'b0}}, cur_r[L-1:1]};
        s_nxt   = {cur_r[0], {L{1'b0}}};
        q_nxt   = '0;
        cnt_nxt = CNT_RATIO;
      end
      UOP_RINIT_G: begin
        cr_nxt  = q_r;
        r_nxt   = {{(L+1){1'b0}}, ghost_r[L-1:1]};
        s_nxt   = {ghost_r[0], {L{1'b0}}};
        q_nxt   = '0;
        cnt_nxt = CNT_RATIO;
      end
      UOP_FINISH: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = cr_r;
          out_ghr_nxt   = q_r;
          out_gl_nxt    = ghost_r;
          out_mode_nxt  = mode_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_ACCEPT;
      hold_r      <= HOLD_RST;
      coll_r      <= COLL_RST;
      fs_r        <= L'(1);
      cur_r       <= '0;
      ghost_r     <= '0;
      start_r     <= '0;
      el_r        <= '0;
      mode_r      <= MODE_IDLE;
      base_r      <= 1'b0;
      need_div_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      hold_r      <= hold_nxt;
      coll_r      <= coll_nxt;
      fs_r        <= fs_nxt;
      cur_r       <= cur_nxt;
      ghost_r     <= ghost_nxt;
      start_r     <= start_nxt;
      el_r        <= el_nxt;
      mode_r      <= mode_nxt;
      base_r      <= base_nxt;
      need_div_r  <= need_div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    m_r        <= m_nxt;
    r_r        <= r_nxt;
    sq_hi_r    <= sq_hi_nxt;
    acc_r      <= acc_nxt;
    s_r        <= s_nxt;
    q_r        <= q_nxt;
    cr_r       <= cr_nxt;
    cnt_r      <= cnt_nxt;
    out_cur_r  <= out_cur_nxt;
    out_ghr_r  <= out_ghr_nxt;
    out_gl_r   <= out_gl_nxt;
    out_mode_r <= out_mode_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_current_ratio = out_cur_r;
  assign out_ghost_ratio   = out_ghr_r;
  assign out_ghost_level   = out_gl_r;
  assign out_trail_mode    = out_mode_r;

endmodule

// ===== hdl/phdm_checker.sv =====
// Port-level checks for the peak-hold meter, bound to the top level.
module phdm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [phdm_pkg::RATIO_W-1:0]  out_current_ratio,
  input logic [phdm_pkg::RATIO_W-1:0]  out_ghost_ratio,
  input logic [1:0]                    out_trail_mode
);
  import phdm_pkg::*;

  localparam logic [RATIO_W-1:0] FULL = RATIO_W'(1) << LEVEL_W;

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_ratio)
      && $stable(out_ghost_ratio) && $stable(out_trail_mode))
    else $error("result beat changed while stalled");

  a_ghost_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ghost_ratio >= out_current_ratio)
    else $error("ghost ratio below current ratio");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ghost_ratio <= FULL) && (out_current_ratio <= FULL))
    else $error("ratio above full scale");

  // with no trail running the ghost sits on the current level
  a_idle_eq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_trail_mode == MODE_IDLE) |-> out_ghost_ratio == out_current_ratio)
    else $error("idle trail with ghost apart from current level");

endmodule

bind peak_hold_eased_decay_meter phdm_checker u_phdm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_current_ratio (out_current_ratio),
  .out_ghost_ratio   (out_ghost_ratio),
  .out_trail_mode    (out_trail_mode)
);
